>>> rtl/system_control_coprocessor_assert.svh
// Assertion macros for the system control coprocessor checker.
`ifndef SYSTEM_CONTROL_COPROCESSOR_ASSERT_SVH
`define SYSTEM_CONTROL_COPROCESSOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define SCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define SCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/scc_pkg.sv
// Types and constants shared by the system control coprocessor files.
package scc_pkg;

    // Function groups selected by the primary register number.
    localparam logic [3:0] GRP_ID      = 4'd0;
    localparam logic [3:0] GRP_CONTROL = 4'd1;
    localparam logic [3:0] GRP_TBASE   = 4'd2;
    localparam logic [3:0] GRP_DOMAIN  = 4'd3;
    localparam logic [3:0] GRP_FSR     = 4'd5;
    localparam logic [3:0] GRP_FAR     = 4'd6;
    localparam logic [3:0] GRP_CACHE   = 4'd7;
    localparam logic [3:0] GRP_TLB     = 4'd8;
    localparam logic [3:0] GRP_LOCK_C  = 4'd9;
    localparam logic [3:0] GRP_LOCK_T  = 4'd10;
    localparam logic [3:0] GRP_PERM    = 4'd15;

    // Secondary register numbers of interest.
    localparam logic [3:0] CRM_ZERO    = 4'd0;
    localparam logic [3:0] CRM_PERM    = 4'd1;
    localparam logic [3:0] CRM_ICACHE  = 4'd5;
    localparam logic [3:0] CRM_IDCACHE = 4'd7;

    // Register variants / operations in opcode_two.
    localparam logic [2:0] VAR_FIRST   = 3'd0;
    localparam logic [2:0] VAR_SECOND  = 3'd1;
    localparam logic [2:0] VAR_THIRD   = 3'd2;

    localparam logic [2:0] OPC1_ZERO   = 3'd0;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_FAULT  = 1'b1;

    // Instruction cache command codes.
    localparam logic [1:0] ICOP_NONE = 2'd0;
    localparam logic [1:0] ICOP_ALL  = 2'd1;
    localparam logic [1:0] ICOP_LINE = 2'd2;

    localparam logic [31:0] ID_MAIN    = 32'h69052D06;
    localparam logic [31:0] ID_CACHE   = 32'h0B16A16A;
    localparam logic [31:0] CTL_BAD    = 32'h000084F0;
    localparam logic [31:0] CTL_V      = 32'h00002000;
    localparam logic [31:0] CTL_R      = 32'h00000200;
    localparam logic [31:0] CTL_S      = 32'h00000100;
    localparam logic [31:0] CTL_M      = 32'h00000001;
    localparam logic [31:0] CTL_APPLY  = CTL_V | CTL_R | CTL_S | CTL_M;
    localparam logic [31:0] CTL_RESET  = 32'h00004072;
    localparam int          PERM_W     = 14;
    localparam logic [PERM_W-1:0] PERM_MASK = 14'h3FFF;

    typedef struct packed {
        logic        action;
        logic        is_read;
        logic        two_form;
        logic [2:0]  opcode_one;
        logic [3:0]  primary_reg;
        logic [3:0]  secondary_reg;
        logic [2:0]  opcode_two;
        logic [3:0]  core_reg;
        logic [31:0] write_value;
        logic [7:0]  fault_code;
    } scc_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
        logic [3:0]  dest_reg;
        logic        write_back;
        logic        control_update;
        logic [31:0] control_now;
        logic        mmu_base_update;
        logic        mmu_on;
        logic [31:0] table_base;
        logic        tlb_flush;
        logic [1:0]  icache_op;
        logic        halted;
    } scc_rsp_t;

    typedef struct packed {
        logic [31:0]       control_word;
        logic [31:0]       aux_control;
        logic [31:0]       table_base;
        logic [31:0]       domain_access;
        logic [31:0]       fault_status;
        logic [31:0]       fault_address;
        logic [PERM_W-1:0] access_perm;
        logic              halt;
    } scc_state_t;

    localparam scc_state_t STATE_RESET = '{
        control_word:  CTL_RESET,
        aux_control:   32'd0,
        table_base:    32'd0,
        domain_access: 32'd0,
        fault_status:  32'd0,
        fault_address: 32'd0,
        access_perm:   '0,
        halt:          1'b0
    };

endpackage

>>> rtl/scc_decode.sv
// Access decoder: result and next register state for one item.
module scc_decode
    import scc_pkg::*;
(
    input  scc_cmd_t   cmd,
    input  scc_state_t cur,
    output scc_state_t nxt,
    output scc_rsp_t   rsp
);

    logic [31:0] data;
    logic [31:0] diff;
    logic [31:0] applied;
    logic        ok;

    always_comb
    begin
        nxt     = cur;
        ok      = 1'b0;
        data    = 32'd0;
        diff    = cmd.write_value ^ cur.control_word;
        applied = diff & CTL_APPLY;
        rsp     = '0;

        if (cur.halt)
        begin
            ok = 1'b0;
        end
        else if (cmd.action == ACT_FAULT)
        begin
            nxt.fault_address = cmd.write_value;
            nxt.fault_status  = {24'd0, cmd.fault_code};
            ok = 1'b1;
        end
        else if (cmd.opcode_one == OPC1_ZERO && !cmd.two_form)
        begin
            case (cmd.primary_reg)
                GRP_ID:
                begin
                    if (cmd.is_read && cmd.secondary_reg == CRM_ZERO)
                    begin
                        if (cmd.opcode_two == VAR_FIRST)
                        begin
                            data = ID_MAIN;
                            ok   = 1'b1;
                        end
                        else if (cmd.opcode_two == VAR_SECOND)
                        begin
                            data = ID_CACHE;
                            ok   = 1'b1;
                        end
                    end
                end
                GRP_CONTROL:
                begin
                    if (cmd.opcode_two == VAR_FIRST)
                    begin
                        if (cmd.is_read)
                        begin
                            data = cur.control_word;
                            ok   = 1'b1;
                        end
                        else if ((diff & CTL_BAD) != 32'd0)
                        begin
                            // unsupported bit change: stop for good
                            nxt.halt = 1'b1;
                        end
                        else
                        begin
                            nxt.control_word   = cur.control_word ^ applied;
                            rsp.control_update = (applied != 32'd0);
                            if ((applied & CTL_M) != 32'd0)
                            begin
                                rsp.mmu_base_update = 1'b1;
                                rsp.mmu_on          = cmd.write_value[0];
                                rsp.table_base      = cmd.write_value[0] ?
                                                      cur.table_base : 32'd0;
                                rsp.tlb_flush       = 1'b1;
                            end
                            ok = 1'b1;
                        end
                    end
                    else if (cmd.opcode_two == VAR_SECOND)
                    begin
                        if (cmd.is_read)
                            data = cur.aux_control;
                        else
                            nxt.aux_control = cmd.write_value;
                        ok = 1'b1;
                    end
                end
                GRP_TBASE:
                begin
                    if (cmd.is_read)
                        data = cur.table_base;
                    else
                    begin
                        if ((cur.control_word & CTL_M) != 32'd0)
                        begin
                            rsp.mmu_base_update = 1'b1;
                            rsp.mmu_on          = 1'b1;
                            rsp.table_base      = cmd.write_value;
                            rsp.tlb_flush       = 1'b1;
                        end
                        nxt.table_base = cmd.write_value;
                    end
                    ok = 1'b1;
                end
                GRP_DOMAIN:
                begin
                    if (cmd.is_read)
                        data = cur.domain_access;
                    else
                        nxt.domain_access = cmd.write_value;
                    ok = 1'b1;
                end
                GRP_FSR:
                begin
                    if (cmd.is_read)
                        data = cur.fault_status;
                    else
                        nxt.fault_status = cmd.write_value;
                    ok = 1'b1;
                end
                GRP_FAR:
                begin
                    if (cmd.is_read)
                        data = cur.fault_address;
                    else
                        nxt.fault_address = cmd.write_value;
                    ok = 1'b1;
                end
                GRP_CACHE:
                begin
                    if (cmd.secondary_reg == CRM_ICACHE || cmd.secondary_reg == CRM_IDCACHE)
                    begin
                        if (cmd.opcode_two == VAR_FIRST || cmd.opcode_two == VAR_THIRD)
                            rsp.icache_op = ICOP_ALL;
                        else if (cmd.opcode_two == VAR_SECOND)
                            rsp.icache_op = ICOP_LINE;
                    end
                    ok = 1'b1;
                end
                GRP_TLB:
                begin
                    rsp.tlb_flush = 1'b1;
                    ok = 1'b1;
                end
                GRP_LOCK_C, GRP_LOCK_T:
                begin
                    ok = 1'b1;
                end
                GRP_PERM:
                begin
                    if (cmd.opcode_two == VAR_FIRST && cmd.secondary_reg == CRM_PERM)
                    begin
                        if (cmd.is_read)
                            data = {{(32-PERM_W){1'b0}}, cur.access_perm};
                        else
                            nxt.access_perm = cmd.write_value[PERM_W-1:0] & PERM_MASK;
                        ok = 1'b1;
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end

        rsp.ok          = ok;
        rsp.read_data   = (ok && cmd.is_read && cmd.action == ACT_ACCESS) ? data : 32'd0;
        rsp.dest_reg    = cmd.core_reg;
        rsp.write_back  = ok && cmd.is_read && cmd.action == ACT_ACCESS;
        rsp.control_now = nxt.control_word;
        rsp.halted      = nxt.halt;
    end

endmodule

>>> rtl/system_control_coprocessor.sv
// Top level of the system control coprocessor register-transfer block.
//
//   channel  dir  handshake             payload
//   -------  ---  --------------------  ----------------------------
//   cmd      in   cmd_valid/cmd_stall   scc_cmd_t (access or fault)
//   rsp      out  rsp_valid/rsp_stall   scc_rsp_t (status, data, cmds)
//
// One item per cycle sustained while rsp is not stalled; an accepted item
// passes the command register, then the result register. The register file
// is updated as an item moves from the command register into the result
// register, so each item sees the state left by the one before it.
// Reset clears both stages and loads the register file reset values.
// A stall on rsp holds the result; the command register then holds its item
// and cmd_stall rises until the result is taken.
module system_control_coprocessor
    import scc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  scc_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output scc_rsp_t rsp
);

    logic       cmd_vld_reg;
    scc_cmd_t   cmd_reg;
    logic       rsp_vld_reg;
    scc_rsp_t   rsp_reg;
    scc_state_t state_reg;
    scc_state_t state_next;
    scc_rsp_t   rsp_next;
    logic       advance;

    // The result register can take a new item when empty or being drained.
    assign advance   = !rsp_vld_reg || !rsp_stall;
    assign cmd_stall = cmd_vld_reg && !advance;

    scc_decode u_decode (
        .cmd (cmd_reg),
        .cur (state_reg),
        .nxt (state_next),
        .rsp (rsp_next)
    );

    // Command register: load on accept, drop when moved on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_vld_reg <= 1'b0;
        else if (!cmd_stall)
            cmd_vld_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            cmd_reg <= cmd;
    end

    // Result register and register file advance together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
            state_reg   <= STATE_RESET;
        end
        else if (advance)
        begin
            rsp_vld_reg <= cmd_vld_reg;
            if (cmd_vld_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cmd_vld_reg)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/scc_checker.sv
// Port-level checker for the system control coprocessor, with its bind.
`include "system_control_coprocessor_assert.svh"

module scc_checker
    import scc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     cmd_valid,
    input logic     cmd_stall,
    input scc_cmd_t cmd,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input scc_rsp_t rsp
);

    logic halt_seen_reg;
    logic halt_seen_next;

    // Remember that a delivered result reported the sticky halt.
    assign halt_seen_next = halt_seen_reg || (rsp_valid && !rsp_stall && rsp.halted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            halt_seen_reg <= 1'b0;
        else
            halt_seen_reg <= halt_seen_next;
    end

    `SCC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")
    `SCC_ASSERT_IMP(a_no_stall_when_empty, !rsp_valid, !cmd_stall, "input stalled with empty output")
    `SCC_ASSERT_IMP(a_halt_sticky, rsp_valid && halt_seen_reg, rsp.halted && !rsp.ok, "access accepted after halt")
    `SCC_ASSERT_NXT(a_stall_holds_input, cmd_valid && cmd_stall, cmd_valid && $stable(cmd), "stalled command changed")

endmodule

bind system_control_coprocessor scc_checker u_scc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> dv/system_control_coprocessor_tb.sv
// Self-checking testbench for the system control coprocessor block.
`timescale 1ns / 100ps

module system_control_coprocessor_tb;
    import scc_pkg::*;

    // Generous run limit: ~530 items, each with a drawn sender gap and receiver
    // stall bounded by MAX_WAIT and the two-stage pipeline, with a wide margin.
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_WAIT     = 13;
    localparam int N_RANDOM     = 500;
    // Cycles to wait after the last result; the pipeline is two deep.
    localparam int DRAIN_CYCLES = 10;

    // Scoreboard: holds its own copy of the register file, computes the
    // result of each accepted command and checks results in order.
    class scc_scoreboard;
        scc_state_t regs;
        scc_rsp_t   rsp_due[$];
        int         errors;
        int         checked;

        function new();
            regs    = STATE_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        // Apply one command to the register file and return its result.
        function scc_rsp_t run_access(scc_cmd_t c);
            scc_rsp_t    r;
            logic        ok;
            logic [31:0] diff;
            logic [31:0] applied;
            r  = '0;
            ok = 1'b0;
            if (regs.halt) begin
                ok = 1'b0;
            end
            else if (c.action == ACT_FAULT) begin
                regs.fault_address = c.write_value;
                regs.fault_status  = {24'd0, c.fault_code};
                ok = 1'b1;
            end
            else if (c.opcode_one == OPC1_ZERO && !c.two_form) begin
                case (c.primary_reg)
                    GRP_ID:
                    begin
                        if (c.is_read && c.secondary_reg == CRM_ZERO) begin
                            if (c.opcode_two == VAR_FIRST) begin
                                r.read_data = ID_MAIN;
                                ok = 1'b1;
                            end
                            else if (c.opcode_two == VAR_SECOND) begin
                                r.read_data = ID_CACHE;
                                ok = 1'b1;
                            end
                        end
                    end
                    GRP_CONTROL:
                    begin
                        if (c.opcode_two == VAR_FIRST) begin
                            if (c.is_read) begin
                                r.read_data = regs.control_word;
                                ok = 1'b1;
                            end
                            else begin
                                diff = c.write_value ^ regs.control_word;
                                if ((diff & CTL_BAD) != 32'd0) begin
                                    // Unsupported bit change: halt for good.
                                    regs.halt = 1'b1;
                                end
                                else begin
                                    applied = diff & CTL_APPLY;
                                    regs.control_word = regs.control_word ^ applied;
                                    r.control_update = (applied != 32'd0);
                                    if ((applied & CTL_M) != 32'd0) begin
                                        r.mmu_base_update = 1'b1;
                                        r.mmu_on     = c.write_value[0];
                                        r.table_base = c.write_value[0] ? regs.table_base
                                                                         : 32'd0;
                                        r.tlb_flush  = 1'b1;
                                    end
                                    ok = 1'b1;
                                end
                            end
                        end
                        else if (c.opcode_two == VAR_SECOND) begin
                            if (c.is_read) r.read_data = regs.aux_control;
                            else regs.aux_control = c.write_value;
                            ok = 1'b1;
                        end
                    end
                    GRP_TBASE:
                    begin
                        if (c.is_read) begin
                            r.read_data = regs.table_base;
                        end
                        else begin
                            if ((regs.control_word & CTL_M) != 32'd0) begin
                                r.mmu_base_update = 1'b1;
                                r.mmu_on     = 1'b1;
                                r.table_base = c.write_value;
                                r.tlb_flush  = 1'b1;
                            end
                            regs.table_base = c.write_value;
                        end
                        ok = 1'b1;
                    end
                    GRP_DOMAIN:
                    begin
                        if (c.is_read) r.read_data = regs.domain_access;
                        else regs.domain_access = c.write_value;
                        ok = 1'b1;
                    end
                    GRP_FSR:
                    begin
                        if (c.is_read) r.read_data = regs.fault_status;
                        else regs.fault_status = c.write_value;
                        ok = 1'b1;
                    end
                    GRP_FAR:
                    begin
                        if (c.is_read) r.read_data = regs.fault_address;
                        else regs.fault_address = c.write_value;
                        ok = 1'b1;
                    end
                    GRP_CACHE:
                    begin
                        if (c.secondary_reg == CRM_ICACHE || c.secondary_reg == CRM_IDCACHE)
                        begin
                            if (c.opcode_two == VAR_FIRST || c.opcode_two == VAR_THIRD)
                                r.icache_op = ICOP_ALL;
                            else if (c.opcode_two == VAR_SECOND)
                                r.icache_op = ICOP_LINE;
                        end
                        ok = 1'b1;
                    end
                    GRP_TLB:
                    begin
                        r.tlb_flush = 1'b1;
                        ok = 1'b1;
                    end
                    GRP_LOCK_C, GRP_LOCK_T:
                    begin
                        ok = 1'b1;
                    end
                    GRP_PERM:
                    begin
                        if (c.opcode_two == VAR_FIRST && c.secondary_reg == CRM_PERM) begin
                            if (c.is_read) r.read_data = {{(32-PERM_W){1'b0}}, regs.access_perm};
                            else regs.access_perm = c.write_value[PERM_W-1:0];
                            ok = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (!ok || !c.is_read || c.action == ACT_FAULT) r.read_data = 32'd0;
            r.ok          = ok;
            r.dest_reg    = c.core_reg;
            r.write_back  = ok && c.is_read && (c.action == ACT_ACCESS);
            r.control_now = regs.control_word;
            r.halted      = regs.halt;
            return r;
        endfunction

        function void note_cmd(scc_cmd_t c);
            rsp_due.push_back(run_access(c));
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: result %0d %s mismatch, expected %h, actual %h",
                         $time, checked, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_rsp(scc_rsp_t a);
            scc_rsp_t e;
            if (rsp_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, a);
                errors++;
                return;
            end
            e = rsp_due.pop_front();
            cmp("ok",              32'(e.ok),              32'(a.ok));
            cmp("read_data",       e.read_data,            a.read_data);
            cmp("dest_reg",        32'(e.dest_reg),        32'(a.dest_reg));
            cmp("write_back",      32'(e.write_back),      32'(a.write_back));
            cmp("control_update",  32'(e.control_update),  32'(a.control_update));
            cmp("control_now",     e.control_now,          a.control_now);
            cmp("mmu_base_update", 32'(e.mmu_base_update), 32'(a.mmu_base_update));
            cmp("mmu_on",          32'(e.mmu_on),          32'(a.mmu_on));
            cmp("table_base",      e.table_base,           a.table_base);
            cmp("tlb_flush",       32'(e.tlb_flush),       32'(a.tlb_flush));
            cmp("icache_op",       32'(e.icache_op),       32'(a.icache_op));
            cmp("halted",          32'(e.halted),          32'(a.halted));
            checked++;
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    scc_cmd_t cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    scc_rsp_t rsp;

    scc_scoreboard sb;
    int  cycles   = 0;
    int  n_sent   = 0;
    bit  cmd_calm = 1'b0;
    bit  rsp_calm = 1'b0;

    system_control_coprocessor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, sb.rsp_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one item: idle for a drawn gap, then hold it until accepted.
    // Keep valid high across back-to-back items so it is never dropped and
    // raised in the same step.
    task automatic send_cmd(input scc_cmd_t c);
        int gap;
        gap = cmd_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        sb.note_cmd(c);
        n_sent++;
        // Re-draw the idling mode now and then, so some stretches run flat out.
        if (n_sent % 40 == 0) cmd_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Build a register-transfer access with a random core register.
    function automatic scc_cmd_t access_cmd(logic rd, logic [3:0] crn, logic [3:0] crm,
                                            logic [2:0] op2, logic [31:0] wv);
        scc_cmd_t c;
        c               = '0;
        c.action        = ACT_ACCESS;
        c.is_read       = rd;
        c.two_form      = 1'b0;
        c.opcode_one    = OPC1_ZERO;
        c.primary_reg   = crn;
        c.secondary_reg = crm;
        c.opcode_two    = op2;
        c.core_reg      = 4'($urandom);
        c.write_value   = wv;
        c.fault_code    = 8'($urandom);
        return c;
    endfunction

    function automatic scc_cmd_t fault_cmd(logic [31:0] addr, logic [7:0] code);
        scc_cmd_t c;
        c             = access_cmd(1'b0, GRP_ID, CRM_ZERO, VAR_FIRST, addr);
        c.action      = ACT_FAULT;
        c.is_read     = 1'($urandom);
        c.fault_code  = code;
        return c;
    endfunction

    // Mostly well-formed accesses with random content; some noise. Control
    // writes keep the unsupported bits as they are so the run does not halt
    // early; the halt is exercised at the very end.
    function automatic scc_cmd_t random_cmd();
        scc_cmd_t    c;
        logic [3:0]  groups [14];
        int          pick;
        groups = '{GRP_ID, GRP_CONTROL, GRP_CONTROL, GRP_TBASE, GRP_TBASE, GRP_DOMAIN,
                   GRP_FSR, GRP_FAR, GRP_CACHE, GRP_CACHE, GRP_TLB, GRP_LOCK_C,
                   GRP_LOCK_T, GRP_PERM};
        c            = '0;
        c.action     = ($urandom_range(0, 9) == 0) ? ACT_FAULT : ACT_ACCESS;
        c.is_read    = 1'($urandom);
        c.two_form   = ($urandom_range(0, 11) == 0);
        c.opcode_one = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : OPC1_ZERO;
        if ($urandom_range(0, 3) == 0) begin
            c.primary_reg = 4'($urandom);
        end
        else begin
            pick = $urandom_range(0, 13);
            c.primary_reg = groups[pick];
        end
        if ($urandom_range(0, 1) == 0) begin
            c.secondary_reg = 4'($urandom);
        end
        else begin
            case (c.primary_reg)
                GRP_ID:    c.secondary_reg = CRM_ZERO;
                GRP_CACHE: c.secondary_reg = $urandom_range(0, 1) ? CRM_ICACHE : CRM_IDCACHE;
                GRP_PERM:  c.secondary_reg = CRM_PERM;
                default:   c.secondary_reg = 4'($urandom);
            endcase
        end
        c.opcode_two = ($urandom_range(0, 4) < 3) ? 3'($urandom_range(0, 2)) : 3'($urandom);
        c.core_reg   = 4'($urandom);
        case ($urandom_range(0, 9))
            0:       c.write_value = 32'd0;
            1:       c.write_value = 32'hFFFF_FFFF;
            default: c.write_value = $urandom;
        endcase
        c.fault_code = 8'($urandom);
        if (c.action == ACT_ACCESS && !c.two_form && c.opcode_one == OPC1_ZERO &&
            c.primary_reg == GRP_CONTROL && c.opcode_two == VAR_FIRST && !c.is_read)
            c.write_value = (c.write_value & ~CTL_BAD) | (sb.regs.control_word & CTL_BAD);
        return c;
    endfunction

    // Receiver: stall for a drawn number of cycles before each result.
    initial
    begin
        int n;
        int got;
        got = 0;
        wait (rst_n === 1'b1);
        forever begin
            n = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (n > 0) begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            sb.check_rsp(rsp);
            got++;
            if (got % 60 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        scc_cmd_t c;
        int       i;
        int       n_directed;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Identification reads: both variants, a bad variant and a write.
        c = access_cmd(1'b1, GRP_ID, CRM_ZERO, VAR_FIRST, 32'd0);
        c.core_reg = 4'd0;
        send_cmd(c);
        c = access_cmd(1'b1, GRP_ID, CRM_ZERO, VAR_SECOND, 32'hFFFF_FFFF);
        c.core_reg = 4'd15;
        send_cmd(c);
        send_cmd(access_cmd(1'b1, GRP_ID, CRM_ZERO, VAR_THIRD, 32'd0));
        send_cmd(access_cmd(1'b0, GRP_ID, CRM_ZERO, VAR_FIRST, 32'd0));

        // Table base with translation off, then on, base rewrite, then off
        // again with V, R, S set. Bit 31 changes and must be ignored.
        send_cmd(access_cmd(1'b0, GRP_TBASE, CRM_ZERO, VAR_FIRST, 32'hFFFF_FFFF));
        send_cmd(access_cmd(1'b0, GRP_CONTROL, CRM_ZERO, VAR_FIRST,
                            sb.regs.control_word | CTL_M | 32'h8000_0000));
        send_cmd(access_cmd(1'b0, GRP_TBASE, CRM_ZERO, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b1, GRP_CONTROL, CRM_ZERO, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b0, GRP_CONTROL, CRM_ZERO, VAR_FIRST,
                            (sb.regs.control_word & ~CTL_M) | CTL_V | CTL_R | CTL_S));
        send_cmd(access_cmd(1'b1, GRP_CONTROL, CRM_ZERO, VAR_THIRD, 32'd0));

        // Plain registers: auxiliary control, domain, access permission.
        send_cmd(access_cmd(1'b0, GRP_CONTROL, CRM_ZERO, VAR_SECOND, 32'hFFFF_FFFF));
        send_cmd(access_cmd(1'b1, GRP_CONTROL, CRM_ZERO, VAR_SECOND, 32'd0));
        send_cmd(access_cmd(1'b0, GRP_DOMAIN, CRM_ZERO, VAR_FIRST, 32'hA5A5_5A5A));
        send_cmd(access_cmd(1'b0, GRP_PERM, CRM_PERM, VAR_FIRST, 32'hFFFF_FFFF));
        send_cmd(access_cmd(1'b1, GRP_PERM, CRM_PERM, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b1, GRP_PERM, CRM_ZERO, VAR_FIRST, 32'd0));

        // Fault record, then read back status and address.
        send_cmd(fault_cmd(32'hFFFF_FFFF, 8'hFF));
        send_cmd(access_cmd(1'b1, GRP_FSR, CRM_ZERO, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b1, GRP_FAR, CRM_ZERO, VAR_FIRST, 32'd0));

        // Cache operations: all, line (as a read), all by variant two,
        // no command for a high variant and for another secondary register.
        send_cmd(access_cmd(1'b0, GRP_CACHE, CRM_ICACHE, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b1, GRP_CACHE, CRM_IDCACHE, VAR_SECOND, 32'h0000_1234));
        send_cmd(access_cmd(1'b0, GRP_CACHE, CRM_ICACHE, VAR_THIRD, 32'd0));
        send_cmd(access_cmd(1'b0, GRP_CACHE, CRM_IDCACHE, 3'd3, 32'd0));
        send_cmd(access_cmd(1'b0, GRP_CACHE, 4'd3, VAR_FIRST, 32'd0));

        // TLB, lockdown, an unmapped group, second form and bad opcode one.
        send_cmd(access_cmd(1'b1, GRP_TLB, CRM_IDCACHE, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b1, GRP_LOCK_C, CRM_ZERO, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b0, GRP_LOCK_T, CRM_ZERO, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b1, 4'd4, CRM_ZERO, VAR_FIRST, 32'd0));
        c = access_cmd(1'b1, GRP_CONTROL, CRM_ZERO, VAR_FIRST, 32'd0);
        c.two_form = 1'b1;
        send_cmd(c);
        c = access_cmd(1'b1, GRP_CONTROL, CRM_ZERO, VAR_FIRST, 32'd0);
        c.opcode_one = 3'd7;
        send_cmd(c);
        n_directed = n_sent;

        for (i = 0; i < N_RANDOM; i++) begin
            send_cmd(random_cmd());
        end

        // Unsupported control change: halt, then every item must fail.
        send_cmd(access_cmd(1'b0, GRP_CONTROL, CRM_ZERO, VAR_FIRST,
                            sb.regs.control_word ^ CTL_BAD));
        send_cmd(fault_cmd($urandom, 8'($urandom)));
        send_cmd(access_cmd(1'b1, GRP_ID, CRM_ZERO, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b1, GRP_CONTROL, CRM_ZERO, VAR_FIRST, 32'd0));
        send_cmd(access_cmd(1'b0, GRP_TBASE, CRM_ZERO, VAR_FIRST, $urandom));
        cmd_valid <= 1'b0;

        // Drain, then keep waiting to catch stray results.
        while (sb.rsp_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.rsp_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.rsp_due.size());
            sb.errors++;
        end

        $display("Drove %0d items (%0d directed, %0d random, rest after halt), checked %0d",
                 n_sent, n_directed, N_RANDOM, sb.checked);
        $display("Covered every access group, MMU and cache commands, faults and halt");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("%0d mismatches", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
